// ===== src/rgasm_pkg.sv =====
// Shared types and constants for the RDS group assembler.
package rgasm_pkg;

  localparam int unsigned ERR_BIT     = 7;
  localparam int unsigned VERSION_BIT = 3;

  localparam logic [2:0] CODE_A       = 3'd0;
  localparam logic [2:0] CODE_B       = 3'd1;
  localparam logic [2:0] CODE_C       = 3'd2;
  localparam logic [2:0] CODE_D       = 3'd3;
  localparam logic [2:0] CODE_C_PRIME = 3'd4;
  localparam logic [2:0] CODE_E0      = 3'd5;
  localparam logic [2:0] CODE_E1      = 3'd6;
  localparam logic [2:0] CODE_BAD     = 3'd7;

  localparam logic [2:0] NO_BLOCK        = 3'd7;
  localparam logic [2:0] NUM_BLOCKS      = 3'd4;
  localparam logic [2:0] TYPE_MIN_BLOCKS = 3'd2;

  typedef enum logic [1:0] {
    ST_WAITING = 2'd0,
    ST_OK      = 2'd1,
    ST_INVALID = 2'd2
  } grp_status_t;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_INVALID = 2'd1,
    CMD_IGNORE  = 2'd2,
    CMD_BLOCK   = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [1:0]  code;
    logic [15:0] word;
  } cmd_t;

  typedef struct packed {
    grp_status_t group_status;
    logic [2:0]  blocks_held;
    logic        type_valid;
    logic [3:0]  group_type;
    logic        is_type_a;
    logic        is_type_b;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
  } result_t;

endpackage

// ===== src/rgasm_front.sv =====
// Front end: classifies each incoming word into a group command.
module rgasm_front import rgasm_pkg::*; (
  input  logic       req_type,
  input  logic [7:0] low_byte,
  input  logic [7:0] high_byte,
  input  logic [7:0] status_byte,
  output cmd_t       cmd
);

  logic [2:0] code;

  assign code = status_byte[2:0];

  always_comb begin
    cmd.kind = CMD_IGNORE;
    cmd.code = 2'd0;
    cmd.word = {high_byte, low_byte};
    if (req_type) begin
      cmd.kind = CMD_CLEAR;
    end else if (status_byte[ERR_BIT]) begin
      cmd.kind = CMD_INVALID;
    end else begin
      case (code) inside
        CODE_A, CODE_B, CODE_C, CODE_D: begin
          cmd.kind = CMD_BLOCK;
          cmd.code = code[1:0];
        end
        CODE_C_PRIME: begin
          cmd.kind = CMD_BLOCK;
          cmd.code = CODE_C[1:0];
        end
        CODE_E0, CODE_E1: begin
          cmd.kind = CMD_IGNORE;
        end
        CODE_BAD: begin
          cmd.kind = CMD_INVALID;
        end
        default: begin
          cmd.kind = CMD_IGNORE;
        end
      endcase
    end
  end

endmodule

// ===== src/rgasm_cmd_fifo.sv =====
// Two-entry command queue between the front end and the group back end.
module rgasm_cmd_fifo import rgasm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic rd_valid
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       do_wr;
  logic       do_rd;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;
  assign rd_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// ===== src/rgasm_back.sv =====
// Back end: applies commands to the group state and queues the results.
module rgasm_back import rgasm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cmd_t    cmd,
  input  logic    cmd_valid,
  output logic    cmd_take,
  output result_t res,
  output logic    res_empty,
  input  logic    res_pop
);

  logic [15:0] words_r   [4];
  logic [15:0] words_nxt [4];
  logic [2:0]  blk_cnt_r;
  logic [2:0]  blk_cnt_nxt;
  logic [2:0]  prev_r;
  logic [2:0]  prev_nxt;
  grp_status_t st_r;
  grp_status_t st_nxt;
  logic [7:0]  b_high;
  logic        tv;
  result_t     res_nxt;

  result_t     oq_mem_r [2];
  logic        oq_wr_r;
  logic        oq_rd_r;
  logic [1:0]  oq_cnt_r;
  logic [1:0]  oq_cnt_nxt;
  logic        oq_pop;

  assign cmd_take = cmd_valid && (oq_cnt_r != 2'd2);

  always_comb begin
    words_nxt   = words_r;
    blk_cnt_nxt = blk_cnt_r;
    prev_nxt    = prev_r;
    st_nxt      = st_r;
    if (cmd_take) begin
      case (cmd.kind)
        CMD_CLEAR: begin
          blk_cnt_nxt = 3'd0;
          prev_nxt    = NO_BLOCK;
          st_nxt      = ST_WAITING;
        end
        CMD_INVALID: begin
          st_nxt = ST_INVALID;
        end
        CMD_BLOCK: begin
          if ({1'b0, cmd.code} == prev_r) begin
            st_nxt = st_r;
          end else if ((blk_cnt_r == 3'd0) && (cmd.code != CODE_A[1:0])) begin
            st_nxt = st_r;
          end else if ({1'b0, cmd.code} != blk_cnt_r) begin
            st_nxt = ST_INVALID;
          end else begin
            words_nxt[cmd.code] = cmd.word;
            blk_cnt_nxt         = blk_cnt_r + 3'd1;
            prev_nxt            = {1'b0, cmd.code};
            if (blk_cnt_r == (NUM_BLOCKS - 3'd1)) begin
              st_nxt = ST_OK;
            end
          end
        end
        default: begin
          st_nxt = st_r;
        end
      endcase
    end
  end

  assign tv     = (blk_cnt_nxt >= TYPE_MIN_BLOCKS);
  assign b_high = words_nxt[1][15:8];

  always_comb begin
    res_nxt.group_status = st_nxt;
    res_nxt.blocks_held  = blk_cnt_nxt;
    res_nxt.type_valid   = tv;
    res_nxt.group_type   = tv ? b_high[7:4] : 4'd0;
    res_nxt.is_type_a    = tv && !b_high[VERSION_BIT];
    res_nxt.is_type_b    = tv && b_high[VERSION_BIT];
    res_nxt.word_a       = (blk_cnt_nxt > 3'd0) ? words_nxt[0] : 16'd0;
    res_nxt.word_b       = (blk_cnt_nxt > 3'd1) ? words_nxt[1] : 16'd0;
    res_nxt.word_c       = (blk_cnt_nxt > 3'd2) ? words_nxt[2] : 16'd0;
    res_nxt.word_d       = (blk_cnt_nxt > 3'd3) ? words_nxt[3] : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_cnt_r <= 3'd0;
      prev_r    <= NO_BLOCK;
      st_r      <= ST_WAITING;
    end else begin
      blk_cnt_r <= blk_cnt_nxt;
      prev_r    <= prev_nxt;
      st_r      <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    words_r <= words_nxt;
  end

  assign res_empty = (oq_cnt_r == 2'd0);
  assign oq_pop    = res_pop && !res_empty;
  assign res       = oq_mem_r[oq_rd_r];

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (cmd_take && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + 2'd1;
    end else if (oq_pop && !cmd_take) begin
      oq_cnt_nxt = oq_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (cmd_take) begin
        oq_wr_r <= !oq_wr_r;
      end
      if (oq_pop) begin
        oq_rd_r <= !oq_rd_r;
      end
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      oq_mem_r[oq_wr_r] <= res_nxt;
    end
  end

endmodule

// ===== src/rds_group_assembler_top.sv =====
// Top level of the RDS group assembler: front end, command queue and back end.
//
//   Channel   Handshake        Payload
//   input     push / full      in_req_type, in_low_byte, in_high_byte, in_status_byte
//   result    pop / empty      out_group_status .. out_word_d
//
// One word is taken per cycle while full is low; its result passes through the command queue and then
// the result queue before it can be popped. The two queues only absorb stalls; with pop held high one
// word per cycle is sustained. Reset is synchronous and clears both queues and the group state at once.
// full rises when the command queue holds two words, which can only start while
// the result queue is full.
module rds_group_assembler_top import rgasm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_req_type,
  input  logic [7:0]  in_low_byte,
  input  logic [7:0]  in_high_byte,
  input  logic [7:0]  in_status_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_group_status,
  output logic [2:0]  out_blocks_held,
  output logic        out_type_valid,
  output logic [3:0]  out_group_type,
  output logic        out_is_type_a,
  output logic        out_is_type_b,
  output logic [15:0] out_word_a,
  output logic [15:0] out_word_b,
  output logic [15:0] out_word_c,
  output logic [15:0] out_word_d
);

  cmd_t    front_cmd;
  cmd_t    q_cmd;
  logic    q_valid;
  logic    q_take;
  result_t res;

  rgasm_front u_front (
    .req_type    (in_req_type),
    .low_byte    (in_low_byte),
    .high_byte   (in_high_byte),
    .status_byte (in_status_byte),
    .cmd         (front_cmd)
  );

  rgasm_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_cmd   (front_cmd),
    .full     (full),
    .rd_en    (q_take),
    .rd_cmd   (q_cmd),
    .rd_valid (q_valid)
  );

  rgasm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .cmd_valid (q_valid),
    .cmd_take  (q_take),
    .res       (res),
    .res_empty (empty),
    .res_pop   (pop)
  );

  assign out_group_status = res.group_status;
  assign out_blocks_held  = res.blocks_held;
  assign out_type_valid   = res.type_valid;
  assign out_group_type   = res.group_type;
  assign out_is_type_a    = res.is_type_a;
  assign out_is_type_b    = res.is_type_b;
  assign out_word_a       = res.word_a;
  assign out_word_b       = res.word_b;
  assign out_word_c       = res.word_c;
  assign out_word_d       = res.word_d;

endmodule

// ===== tb/rgasm_check_pkg.sv =====
// Scoreboard that predicts and checks the words of the RDS group assembler.
package rgasm_check_pkg;
  import rgasm_pkg::*;

  class group_scoreboard;
    logic [15:0] block_words[4];
    logic [2:0]  held;
    logic [2:0]  last_code;
    grp_status_t status;
    result_t     pending[$];
    int          errors;

    function new();
      foreach (block_words[i]) block_words[i] = 16'h0000;
      held = 3'd0;
      last_code = NO_BLOCK;
      status = ST_WAITING;
      errors = 0;
    endfunction

    function void note_word(logic req, logic [7:0] lo, logic [7:0] hi, logic [7:0] st);
      logic [2:0] code;
      logic       tv;
      logic [7:0] bhi;
      result_t    r;
      if (req) begin
        held = 3'd0;
        last_code = NO_BLOCK;
        status = ST_WAITING;
      end else if (st[ERR_BIT]) begin
        status = ST_INVALID;
      end else begin
        code = st[2:0];
        if (code == CODE_C_PRIME) code = CODE_C;
        if (code == CODE_BAD) begin
          status = ST_INVALID;
        end else if (code == CODE_E0 || code == CODE_E1 || code == last_code) begin
        end else if (held == 3'd0 && code != CODE_A) begin
        end else if (code != held) begin
          status = ST_INVALID;
        end else begin
          block_words[code[1:0]] = {hi, lo};
          held = held + 3'd1;
          last_code = code;
          if (held >= NUM_BLOCKS) status = ST_OK;
        end
      end
      tv = (held >= TYPE_MIN_BLOCKS);
      bhi = block_words[1][15:8];
      r.group_status = status;
      r.blocks_held = held;
      r.type_valid = tv;
      r.group_type = tv ? bhi[7:4] : 4'h0;
      r.is_type_a = tv && !bhi[VERSION_BIT];
      r.is_type_b = tv && bhi[VERSION_BIT];
      r.word_a = (held > 3'd0) ? block_words[0] : 16'h0000;
      r.word_b = (held > 3'd1) ? block_words[1] : 16'h0000;
      r.word_c = (held > 3'd2) ? block_words[2] : 16'h0000;
      r.word_d = (held > 3'd3) ? block_words[3] : 16'h0000;
      pending.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected result word: expected none actual %0h", $time, got);
      end else begin
        want = pending.pop_front();
        compare_field("group_status", want.group_status, got.group_status);
        compare_field("blocks_held", want.blocks_held, got.blocks_held);
        compare_field("type_valid", want.type_valid, got.type_valid);
        compare_field("group_type", want.group_type, got.group_type);
        compare_field("is_type_a", want.is_type_a, got.is_type_a);
        compare_field("is_type_b", want.is_type_b, got.is_type_b);
        compare_field("word_a", want.word_a, got.word_a);
        compare_field("word_b", want.word_b, got.word_b);
        compare_field("word_c", want.word_c, got.word_c);
        compare_field("word_d", want.word_d, got.word_d);
      end
    endfunction
  endclass

endpackage

// ===== tb/rds_group_assembler_top_test.sv =====
// Random and directed regression of the RDS group assembler top level.
module rds_group_assembler_top_test;
  import rgasm_pkg::*;
  import rgasm_check_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TARGET_WORDS   = 700;
  localparam int CALM_AFTER     = 600;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        in_req_type = 1'b0;
  logic [7:0]  in_low_byte = 8'h00;
  logic [7:0]  in_high_byte = 8'h00;
  logic [7:0]  in_status_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_group_status;
  logic [2:0]  out_blocks_held;
  logic        out_type_valid;
  logic [3:0]  out_group_type;
  logic        out_is_type_a;
  logic        out_is_type_b;
  logic [15:0] out_word_a;
  logic [15:0] out_word_b;
  logic [15:0] out_word_c;
  logic [15:0] out_word_d;

  result_t         seen;
  group_scoreboard sb = new();
  int              words_sent = 0;
  int              stall_left = 0;
  int              quiet_cycles = 0;
  logic            calm = 1'b0;

  assign seen = {out_group_status, out_blocks_held, out_type_valid, out_group_type,
                 out_is_type_a, out_is_type_b, out_word_a, out_word_b, out_word_c,
                 out_word_d};

  rds_group_assembler_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_req_type(in_req_type),
    .in_low_byte(in_low_byte),
    .in_high_byte(in_high_byte),
    .in_status_byte(in_status_byte),
    .empty(empty),
    .pop(pop),
    .out_group_status(out_group_status),
    .out_blocks_held(out_blocks_held),
    .out_type_valid(out_type_valid),
    .out_group_type(out_group_type),
    .out_is_type_a(out_is_type_a),
    .out_is_type_b(out_is_type_b),
    .out_word_a(out_word_a),
    .out_word_b(out_word_b),
    .out_word_c(out_word_c),
    .out_word_d(out_word_d)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic send_word(input logic req, input logic [7:0] lo, input logic [7:0] hi,
                           input logic [7:0] st);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    push <= 1'b1;
    in_req_type <= req;
    in_low_byte <= lo;
    in_high_byte <= hi;
    in_status_byte <= st;
    do @(posedge clk); while (full);
    sb.note_word(req, lo, hi, st);
    words_sent++;
    if (words_sent >= CALM_AFTER) calm = 1'b1;
  endtask

  task automatic send_block(input logic [7:0] st, input logic [15:0] w);
    send_word(1'b0, w[7:0], w[15:8], st);
  endtask

  task automatic send_noise();
    int         pick;
    logic [7:0] st;
    pick = $urandom_range(0, 4);
    case (pick)
      0: st = {1'b1, 7'($urandom)};
      1: st = {1'b0, 4'($urandom), CODE_BAD};
      2: st = {1'b0, 4'($urandom), ($urandom_range(0, 1) ? CODE_E0 : CODE_E1)};
      default: st = 8'($urandom);
    endcase
    send_word(pick == 4, 8'($urandom), 8'($urandom), st);
  endtask

  task automatic send_group();
    logic [2:0] code;
    logic [7:0] st;
    if ($urandom_range(0, 2) == 0) send_word(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
    for (int k = 0; k < 4; k++) begin
      code = 3'(k);
      if (code == CODE_C && $urandom_range(0, 1) == 1) code = CODE_C_PRIME;
      if ($urandom_range(0, 7) == 0) send_noise();
      st = {1'b0, 4'($urandom), code};
      send_block(st, 16'($urandom));
      if ($urandom_range(0, 9) == 0) send_block(st, 16'($urandom));
    end
  endtask

  task automatic run_directed();
    send_word(1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_block({5'h00, CODE_B}, 16'h1234);
    send_block({5'h00, CODE_A}, 16'h0000);
    send_block({5'h00, CODE_B}, 16'hFF00);
    send_block({5'h00, CODE_C_PRIME}, 16'h00FF);
    send_block({5'h00, CODE_D}, 16'hA55A);
    send_block({5'h00, CODE_A}, 16'h5A5A);
    send_word(1'b1, 8'h00, 8'h00, 8'h00);
    send_block({5'h0F, CODE_A}, 16'hFFFF);
    send_block({5'h00, CODE_A}, 16'h1111);
    send_block({5'h00, CODE_E0}, 16'h2222);
    send_block({5'h00, CODE_E1}, 16'h3333);
    send_block({1'b1, 4'h0, CODE_B}, 16'h4444);
    send_block({5'h00, CODE_BAD}, 16'h5555);
    send_block({5'h00, CODE_B}, 16'h07FF);
    send_block({5'h00, CODE_D}, 16'h6666);
    send_block({5'h00, CODE_C}, 16'hFFFF);
    send_block({5'h00, CODE_D}, 16'hFFFF);
    send_block({1'b1, 4'hF, CODE_BAD}, 16'h7777);
    send_word(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
    send_block({5'h00, CODE_C_PRIME}, 16'h8888);
    send_block({5'h00, CODE_A}, 16'h8000);
    send_block({5'h00, CODE_B}, 16'h2801);
    send_word(1'b1, 8'h00, 8'h00, 8'h00);
  endtask

  always @(posedge clk) begin
    if (pop && !empty) sb.check_result(seen);
    if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      stall_left = $urandom_range(1, 10) - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    while (words_sent < TARGET_WORDS) send_group();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== rds_group_assembler_top.f =====
src/rgasm_pkg.sv
src/rgasm_front.sv
src/rgasm_cmd_fifo.sv
src/rgasm_back.sv
src/rds_group_assembler_top.sv
tb/rgasm_check_pkg.sv
tb/rds_group_assembler_top_test.sv
